[design/escaped_frame_receiver_assert.svh]
// ----------------------------------------------------------------------------
// Escaped frame receiver assertion macros
// Shared concurrent assertion forms, sampled on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_RECEIVER_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define EFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define EFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/efr_pkg.sv]
// ----------------------------------------------------------------------------
// Escaped frame receiver package
// Shared types, codes and constants of the byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package efr_pkg;

    localparam int unsigned EFR_MAX_FRAME = 256;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned FRAME_LEN_W   = 9;
    localparam int unsigned CFG_INDEX_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_START  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE = 2'd2;

    // Codes that follow an escape byte
    localparam logic [BYTE_W-1:0] ESC_CODE_START  = 8'h01;
    localparam logic [BYTE_W-1:0] ESC_CODE_ESCAPE = 8'h02;
    localparam logic [BYTE_W-1:0] ESC_CODE_END    = 8'h03;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] START_RESET  = 8'd126;
    localparam logic [BYTE_W-1:0] END_RESET    = 8'd127;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd125;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } efr_kind_t;

    typedef enum logic [2:0] {
        MODE_WAIT = 3'b001,
        MODE_READ = 3'b010,
        MODE_ESC  = 3'b100
    } efr_mode_t;

    typedef struct packed {
        efr_kind_t               kind;
        logic [BYTE_W-1:0]       payload;
        logic [FRAME_LEN_W-1:0]  length;
    } efr_result_t;

endpackage

`default_nettype wire

[design/efr_decoder.sv]
// ----------------------------------------------------------------------------
// Escaped frame receiver decoder
// Frame state, unescaping, checksum and hold-back of one byte per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "escaped_frame_receiver_assert.svh"

module efr_decoder #(
    parameter int unsigned MAX_FRAME = efr_pkg::EFR_MAX_FRAME
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [efr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [efr_pkg::BYTE_W-1:0]         cfg_data,
    input  wire logic                               accept,
    input  wire logic [efr_pkg::BYTE_W-1:0]         rx_byte,
    output logic                                    res_valid,
    output efr_pkg::efr_result_t                    res
);

    import efr_pkg::*;

    localparam int unsigned CW = $clog2(MAX_FRAME + 1);
    localparam int unsigned LW = (CW > FRAME_LEN_W) ? CW : FRAME_LEN_W;

    logic [BYTE_W-1:0] start_reg;
    logic [BYTE_W-1:0] end_reg;
    logic [BYTE_W-1:0] escape_reg;

    efr_mode_t         mode_reg,       mode_next;
    logic [CW-1:0]     count_reg,      count_next;
    logic [BYTE_W-1:0] sum_reg,        sum_next;
    logic [BYTE_W-1:0] held_reg,       held_next;
    logic              held_valid_reg, held_valid_next;

    logic              do_take;
    logic [BYTE_W-1:0] take_val;
    logic [CW-1:0]     len_cnt;
    logic [LW-1:0]     len_ext;

    assign len_cnt = count_reg - CW'(1);
    assign len_ext = LW'(len_cnt);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= START_RESET;
            end_reg    <= END_RESET;
            escape_reg <= ESCAPE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START:  start_reg  <= cfg_data;
                CFG_END:    end_reg    <= cfg_data;
                CFG_ESCAPE: escape_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        mode_next       = mode_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        res_valid       = 1'b0;
        res             = '0;
        res.kind        = KIND_DATA;
        do_take         = 1'b0;
        take_val        = rx_byte;

        if (accept)
        begin
            if (rx_byte == start_reg)
            begin
                // Resync: a frame still open is reported as cut off
                res_valid       = (mode_reg != MODE_WAIT);
                res.kind        = KIND_BAD;
                mode_next       = MODE_READ;
                count_next      = '0;
                sum_next        = '0;
                held_next       = '0;
                held_valid_next = 1'b0;
            end
            else
            begin
                case (mode_reg)
                    MODE_READ:
                    begin
                        if (rx_byte == escape_reg)
                        begin
                            mode_next = MODE_ESC;
                        end
                        else if (rx_byte == end_reg)
                        begin
                            res_valid       = 1'b1;
                            if (held_valid_reg && (sum_reg == held_reg))
                            begin
                                res.kind   = KIND_GOOD;
                                res.length = len_ext[FRAME_LEN_W-1:0];
                            end
                            else
                            begin
                                res.kind = KIND_BAD;
                            end
                            mode_next       = MODE_WAIT;
                            count_next      = '0;
                            sum_next        = '0;
                            held_next       = '0;
                            held_valid_next = 1'b0;
                        end
                        else
                        begin
                            do_take = 1'b1;
                        end
                    end
                    MODE_ESC:
                    begin
                        if (rx_byte == ESC_CODE_START)
                        begin
                            do_take  = 1'b1;
                            take_val = start_reg;
                        end
                        else if (rx_byte == ESC_CODE_ESCAPE)
                        begin
                            do_take  = 1'b1;
                            take_val = escape_reg;
                        end
                        else if (rx_byte == ESC_CODE_END)
                        begin
                            do_take  = 1'b1;
                            take_val = end_reg;
                        end
                        else
                        begin
                            // Bad escape: drop the frame
                            res_valid       = 1'b1;
                            res.kind        = KIND_BAD;
                            mode_next       = MODE_WAIT;
                            count_next      = '0;
                            sum_next        = '0;
                            held_next       = '0;
                            held_valid_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_WAIT;
                    end
                endcase

                if (do_take)
                begin
                    if (count_reg >= CW'(MAX_FRAME))
                    begin
                        // Overflow: drop the frame
                        res_valid       = 1'b1;
                        res.kind        = KIND_BAD;
                        mode_next       = MODE_WAIT;
                        count_next      = '0;
                        sum_next        = '0;
                        held_next       = '0;
                        held_valid_next = 1'b0;
                    end
                    else
                    begin
                        // Release the held byte, hold this one
                        mode_next  = MODE_READ;
                        count_next = count_reg + CW'(1);
                        if (held_valid_reg)
                        begin
                            res_valid   = 1'b1;
                            res.kind    = KIND_DATA;
                            res.payload = held_reg;
                            sum_next    = sum_reg + held_reg;
                        end
                        held_next       = take_val;
                        held_valid_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_WAIT;
            count_reg      <= '0;
            sum_reg        <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
        end
    end

    `EFR_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(MAX_FRAME),
        "byte count beyond frame limit")
    `EFR_ASSERT_IMP(a_held_in_frame, held_valid_reg,
        (count_reg != '0) && (mode_reg != MODE_WAIT), "held byte outside a frame")
    `EFR_ASSERT_IMP(a_wait_clean, mode_reg == MODE_WAIT,
        (count_reg == '0) && !held_valid_reg && (sum_reg == '0), "idle state not cleared")

endmodule

`default_nettype wire

[design/efr_out_skid.sv]
// ----------------------------------------------------------------------------
// Escaped frame receiver output stage
// Result register with one skid entry, so input transfers go on under stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "escaped_frame_receiver_assert.svh"

module efr_out_skid (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   res_valid,
    input  wire efr_pkg::efr_result_t   res,
    output logic                        full,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output efr_pkg::efr_result_t        out_res
);

    import efr_pkg::*;

    logic        out_valid_reg,  out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    efr_result_t out_reg,        out_next;
    efr_result_t skid_reg,       skid_next;
    logic        load;

    // Output register may take new data when empty or being drained
    assign load = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (load)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_next       = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    `EFR_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid entry without output entry")
    `EFR_ASSERT_IMP(a_no_overrun, skid_valid_reg, !res_valid,
        "result arrived while skid entry full")
    `EFR_ASSERT_NEXT(a_stall_to_skid, res_valid && out_valid_reg && out_stall,
        skid_valid_reg, "stalled result not captured")

endmodule

`default_nettype wire

[design/escaped_frame_receiver.sv]
// ----------------------------------------------------------------------------
// Escaped frame receiver
// Byte-stuffed frame decoder with additive checksum for a serial receive path.
// ----------------------------------------------------------------------------
// Takes one raw received byte per transfer, every cycle while in_stall is low,
// and gives at most one result per byte: a payload byte (held back by one so the
// trailing checksum is never passed on), a good close with the payload length,
// or a bad/dropped frame. The decode is a single stage between the frame state
// registers and the result register; a result goes into that register unless
// the output is stalled. A two-entry output stage (result register plus skid
// entry) lets the block take in one more result after out_stall rises; bytes
// that give no result keep flowing until then, and in_stall is high only while
// the skid entry is occupied. The user must write delimiter and escape values
// through the cfg port only while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module escaped_frame_receiver #(
    parameter int unsigned MAX_FRAME = efr_pkg::EFR_MAX_FRAME
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [efr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [efr_pkg::BYTE_W-1:0]         cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [efr_pkg::BYTE_W-1:0]         rx_byte,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [1:0]                              kind,
    output logic [efr_pkg::BYTE_W-1:0]              payload_byte,
    output logic [efr_pkg::FRAME_LEN_W-1:0]         frame_length
);

    import efr_pkg::*;

    logic        accept;
    logic        res_valid;
    efr_result_t res;
    efr_result_t out_res;
    logic        full;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    efr_decoder #(
        .MAX_FRAME (MAX_FRAME)
    ) u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    efr_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign kind         = 2'(out_res.kind);
    assign payload_byte = out_res.payload;
    assign frame_length = out_res.length;

endmodule

`default_nettype wire
